### hw/rtl/edd_pkg.sv
// Shared types, widths, codes and the saturation helper for the distance derivative core.
`default_nettype none

package edd_pkg;

  // Coordinate and arithmetic widths
  localparam int MAX_DIM    = 3;
  localparam int DIM_RESET  = 3;
  localparam int CW         = 24;  // input coordinate, Q8.16
  localparam int DW         = 25;  // difference, exact
  localparam int SW         = 50;  // sum of squares, Q.32
  localparam int QW         = 25;  // integer square root
  localparam int AW         = 50;  // divider dividend
  localparam int BW         = 57;  // divider divisor
  localparam int RW         = 58;  // divider partial remainder
  localparam int XW         = 34;  // divider quotient
  localparam int RMW        = 28;  // square root partial remainder
  localparam int SQ_STAGES  = 25;
  localparam int DIV_STAGES = 34;

  // Mode codes
  localparam logic [2:0] MODE_DIST = 3'd0;
  localparam logic [2:0] MODE_D1   = 3'd1;
  localparam logic [2:0] MODE_D2   = 3'd2;
  localparam logic [2:0] MODE_GRAD = 3'd3;
  localparam logic [2:0] MODE_HESS = 3'd4;
  localparam logic [2:0] MODE_LAP  = 3'd5;

  // Per-result job kinds
  localparam logic [2:0] KIND_NONE = 3'd0;
  localparam logic [2:0] KIND_DIST = 3'd1;
  localparam logic [2:0] KIND_D1   = 3'd2;
  localparam logic [2:0] KIND_HESS = 3'd3;
  localparam logic [2:0] KIND_LAP  = 3'd4;

  typedef struct packed {
    logic [2:0]           mode;
    logic [1:0]           axis;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;
    logic signed [CW-1:0] centre_x;
    logic signed [CW-1:0] centre_y;
    logic signed [CW-1:0] centre_z;
  } edd_in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [3:0]         element;
    logic               last;
    logic               status;
  } edd_out_t;

  // One result job as issued by the sequencer
  typedef struct packed {
    logic [2:0] kind;
    logic [1:0] i;
    logic [1:0] j;
    logic [3:0] element;
    logic       last;
    logic       status;
    logic [1:0] dm1;
  } edd_job_t;

  // Sideband that rides along the divider pipelines
  typedef struct packed {
    logic [2:0]    kind;
    logic [3:0]    element;
    logic          last;
    logic          status;
    logic          neg;
    logic          zero;
    logic [QW-1:0] q;
  } edd_tag_t;

  // Sideband that rides along the square root pipeline
  typedef struct packed {
    edd_tag_t      tag;
    logic [SW-1:0] s;
    logic [AW-1:0] amag;
  } edd_pre_t;

  // Clamp a magnitude and sign to the signed 32-bit range
  function automatic logic signed [31:0] edd_sat(input logic [XW-1:0] mag, input logic neg);
    if (neg) begin
      if (mag >= XW'(34'h080000000)) return 32'sh80000000;
      return -$signed({1'b0, mag[30:0]});
    end
    if (mag >= XW'(34'h07FFFFFFF)) return 32'sh7FFFFFFF;
    return $signed({1'b0, mag[30:0]});
  endfunction

endpackage

`default_nettype wire

### hw/rtl/edd_lane.sv
// One coordinate lane: difference and its square, two register stages.
`default_nettype none

module edd_lane import edd_pkg::*; (
  input  logic                 clk,
  input  logic                 lane_en,
  input  logic signed [CW-1:0] point,
  input  logic signed [CW-1:0] centre,
  output logic signed [DW-1:0] diff,
  output logic [SW-1:0]        sq
);

  logic signed [DW-1:0]   d1_r;
  logic signed [DW-1:0]   d2_r;
  logic [SW-1:0]          sq_r;
  logic signed [2*DW-1:0] prod;

  assign prod = d1_r * d1_r;

  // Form the difference, then square it; drop lanes beyond the dimension
  always_ff @(posedge clk) begin
    d1_r <= lane_en ? (DW'(point) - DW'(centre)) : '0;
    d2_r <= d1_r;
    sq_r <= prod;
  end

  assign diff = d2_r;
  assign sq   = sq_r;

endmodule

`default_nettype wire

### hw/rtl/edd_sqrt.sv
// Pipelined integer square root, one result bit per stage.
`default_nettype none

module edd_sqrt import edd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  edd_pre_t      in_pre,
  output logic          out_valid,
  output logic [QW-1:0] out_root,
  output edd_pre_t      out_pre
);

  logic           v_r    [1:SQ_STAGES];
  logic [RMW-1:0] rem_r  [1:SQ_STAGES];
  logic [QW-1:0]  root_r [1:SQ_STAGES];
  edd_pre_t       pre_r  [1:SQ_STAGES];

  logic           src_v    [0:SQ_STAGES-1];
  logic [RMW-1:0] src_rem  [0:SQ_STAGES-1];
  logic [QW-1:0]  src_root [0:SQ_STAGES-1];
  edd_pre_t       src_pre  [0:SQ_STAGES-1];

  logic [RMW-1:0] rem2     [0:SQ_STAGES-1];
  logic [RMW-1:0] trial    [0:SQ_STAGES-1];
  logic           ge       [0:SQ_STAGES-1];
  logic [RMW-1:0] rem_nxt  [0:SQ_STAGES-1];
  logic [QW-1:0]  root_nxt [0:SQ_STAGES-1];

  // Feed each stage from the previous register or from the port
  always_comb begin
    src_v[0]    = in_valid;
    src_rem[0]  = '0;
    src_root[0] = '0;
    src_pre[0]  = in_pre;
    for (int t = 1; t < SQ_STAGES; t++) begin
      src_v[t]    = v_r[t];
      src_rem[t]  = rem_r[t];
      src_root[t] = root_r[t];
      src_pre[t]  = pre_r[t];
    end
  end

  // Bring down two radicand bits and try the next root bit
  always_comb begin
    for (int t = 0; t < SQ_STAGES; t++) begin
      rem2[t]     = {src_rem[t][RMW-3:0], src_pre[t].s[SW-2-2*t +: 2]};
      trial[t]    = {1'b0, src_root[t], 2'b01};
      ge[t]       = rem2[t] >= trial[t];
      rem_nxt[t]  = ge[t] ? (rem2[t] - trial[t]) : rem2[t];
      root_nxt[t] = {src_root[t][QW-2:0], ge[t]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 1; t <= SQ_STAGES; t++) v_r[t] <= 1'b0;
    end else begin
      for (int t = 0; t < SQ_STAGES; t++) v_r[t+1] <= src_v[t];
    end
  end

  always_ff @(posedge clk) begin
    for (int t = 0; t < SQ_STAGES; t++) begin
      rem_r[t+1]  <= rem_nxt[t];
      root_r[t+1] <= root_nxt[t];
      pre_r[t+1]  <= src_pre[t];
    end
  end

  assign out_valid = v_r[SQ_STAGES];
  assign out_root  = root_r[SQ_STAGES];
  assign out_pre   = pre_r[SQ_STAGES];

endmodule

`default_nettype wire

### hw/rtl/edd_div.sv
// Pipelined restoring divider: floor(a * 2^32 / b), one quotient bit per stage.
`default_nettype none

module edd_div import edd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [AW-1:0] in_a,
  input  logic [BW-1:0] in_b,
  input  edd_tag_t      in_tag,
  output logic          out_valid,
  output logic [XW-1:0] out_quo,
  output edd_tag_t      out_tag
);

  logic          v_r   [1:DIV_STAGES];
  logic [RW-1:0] r_r   [1:DIV_STAGES];
  logic [XW-1:0] q_r   [1:DIV_STAGES];
  logic [BW-1:0] b_r   [1:DIV_STAGES];
  logic [1:0]    lo_r  [1:DIV_STAGES];
  edd_tag_t      tag_r [1:DIV_STAGES];

  logic          src_v   [0:DIV_STAGES-1];
  logic [RW-1:0] src_r   [0:DIV_STAGES-1];
  logic [XW-1:0] src_q   [0:DIV_STAGES-1];
  logic [BW-1:0] src_b   [0:DIV_STAGES-1];
  logic [1:0]    src_lo  [0:DIV_STAGES-1];
  edd_tag_t      src_tag [0:DIV_STAGES-1];

  logic          inbit [0:DIV_STAGES-1];
  logic [RW:0]   sh    [0:DIV_STAGES-1];
  logic [RW:0]   diff  [0:DIV_STAGES-1];
  logic          ge    [0:DIV_STAGES-1];
  logic [RW-1:0] r_nxt [0:DIV_STAGES-1];
  logic [XW-1:0] q_nxt [0:DIV_STAGES-1];

  // Feed each stage from the previous register or from the port
  always_comb begin
    src_v[0]   = in_valid;
    src_r[0]   = RW'(in_a >> 2);
    src_q[0]   = '0;
    src_b[0]   = in_b;
    src_lo[0]  = in_a[1:0];
    src_tag[0] = in_tag;
    for (int t = 1; t < DIV_STAGES; t++) begin
      src_v[t]   = v_r[t];
      src_r[t]   = r_r[t];
      src_q[t]   = q_r[t];
      src_b[t]   = b_r[t];
      src_lo[t]  = lo_r[t];
      src_tag[t] = tag_r[t];
    end
  end

  // Shift in the next dividend bit and subtract when it fits
  always_comb begin
    for (int t = 0; t < DIV_STAGES; t++) begin
      if (t == 0) inbit[t] = src_lo[t][1];
      else if (t == 1) inbit[t] = src_lo[t][0];
      else inbit[t] = 1'b0;
      sh[t]    = {src_r[t], inbit[t]};
      diff[t]  = sh[t] - {2'b00, src_b[t]};
      ge[t]    = sh[t] >= {2'b00, src_b[t]};
      r_nxt[t] = ge[t] ? diff[t][RW-1:0] : sh[t][RW-1:0];
      q_nxt[t] = {src_q[t][XW-2:0], ge[t]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 1; t <= DIV_STAGES; t++) v_r[t] <= 1'b0;
    end else begin
      for (int t = 0; t < DIV_STAGES; t++) v_r[t+1] <= src_v[t];
    end
  end

  always_ff @(posedge clk) begin
    for (int t = 0; t < DIV_STAGES; t++) begin
      r_r[t+1]   <= r_nxt[t];
      q_r[t+1]   <= q_nxt[t];
      b_r[t+1]   <= src_b[t];
      lo_r[t+1]  <= src_lo[t];
      tag_r[t+1] <= src_tag[t];
    end
  end

  assign out_valid = v_r[DIV_STAGES];
  assign out_quo   = q_r[DIV_STAGES];
  assign out_tag   = tag_r[DIV_STAGES];

endmodule

`default_nettype wire

### hw/rtl/euclidean_distance_derivatives_core.sv
// Top level: job sequencer, coordinate lanes, merge, square root and two dividers.
//
//   channel  ports                               direction  beat taken when
//   -------  ----------------------------------  ---------  ----------------------
//   input    start, busy, in_item                in         start && !busy
//   result   out_strobe, out_item                out        out_strobe (no stall)
//   config   cfg_valid, cfg_ready, cfg_dimension in         cfg_valid && cfg_ready
//
// Each input beat expands into one result job per cycle: one job for scalar modes,
// D for the gradient, D*D for the Hessian; busy stays high while the sequencer
// issues the remaining jobs, so a scalar item can be started every cycle.
// Every job passes through the fixed pipeline of 4 lane/merge stages, 25 root stages,
// two 34-stage dividers and their input and output registers. Reset clears only
// busy and the valid bits and sets dimension to 3.
`default_nettype none

module euclidean_distance_derivatives_core import edd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  edd_in_t    in_item,
  output logic       out_strobe,
  output edd_out_t   out_item,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_dimension
);

  // Sequencer state
  logic       busy_r, busy_nxt;
  edd_in_t    hold_r, hold_nxt;
  logic [1:0] row_r, row_nxt;
  logic [1:0] col_r, col_nxt;
  logic [3:0] elem_r, elem_nxt;
  logic [1:0] dim_r;
  logic [1:0] dim_eff;
  logic [1:0] dm1;
  logic       accept;
  logic       job_valid;
  edd_in_t    src;
  logic [1:0] ci, cj;
  logic [3:0] ck;
  edd_job_t   job;

  // Lane and merge stages
  logic signed [CW-1:0] pts  [0:MAX_DIM-1];
  logic signed [CW-1:0] cts  [0:MAX_DIM-1];
  logic signed [DW-1:0] dl   [0:MAX_DIM-1];
  logic [SW-1:0]        sql  [0:MAX_DIM-1];
  logic                 v1_r, v2_r, v3_r, v4_r;
  edd_job_t             j1_r, j2_r, j3_r;
  logic [SW-1:0]        s_sum;
  logic [SW-1:0]        s3_r;
  logic signed [SW-1:0] prod3_r;
  logic signed [DW-1:0] di3_r;
  edd_pre_t             pre4_r, pre4_nxt;
  logic                 diag;
  logic [SW-1:0]        prod_mag;
  logic [SW-1:0]        nmag;
  logic                 nneg;
  logic [DW-1:0]        di_mag;

  // Root and divider stages
  logic          sq_v;
  logic [QW-1:0] sq_root;
  edd_pre_t      sq_pre;
  logic          vd1_r;
  logic [AW-1:0] d1a_r;
  logic [BW-1:0] d1b_r, b1;
  edd_tag_t      d1t_r, t1;
  logic          dv1;
  logic [XW-1:0] quo1;
  edd_tag_t      dt1;
  logic          vd2_r;
  logic [AW-1:0] d2a_r;
  logic [BW-1:0] d2b_r;
  edd_tag_t      d2t_r;
  logic          dv2;
  logic [XW-1:0] quo2;
  edd_tag_t      dt2;
  logic          out_v_r;
  edd_out_t      out_r, out_nxt;

  // Clamp the configured dimension into the legal range
  always_comb begin
    if (dim_r == 2'd0) dim_eff = 2'd1;
    else if (dim_r > 2'(MAX_DIM)) dim_eff = 2'(MAX_DIM);
    else dim_eff = dim_r;
    dm1 = dim_eff - 2'd1;
  end

  assign accept    = start && !busy_r;
  assign job_valid = accept || busy_r;
  assign busy      = busy_r;
  assign cfg_ready = 1'b1;

  // Build the current job from the new beat or from the held item
  always_comb begin
    src = busy_r ? hold_r : in_item;
    ci  = busy_r ? row_r : 2'd0;
    cj  = busy_r ? col_r : 2'd0;
    ck  = busy_r ? elem_r : 4'd0;
    job = '0;
    job.dm1  = dm1;
    job.last = 1'b1;
    unique case (src.mode) inside
      MODE_DIST: begin
        job.kind = KIND_DIST;
      end
      MODE_D1, MODE_D2: begin
        if (src.axis >= dim_eff) begin
          job.kind   = KIND_NONE;
          job.status = 1'b1;
        end else begin
          job.kind = (src.mode == MODE_D1) ? KIND_D1 : KIND_HESS;
          job.i    = src.axis;
          job.j    = src.axis;
        end
      end
      MODE_GRAD: begin
        job.kind    = KIND_D1;
        job.i       = ci;
        job.j       = ci;
        job.element = ck;
        job.last    = (ci == dm1);
      end
      MODE_HESS: begin
        job.kind    = KIND_HESS;
        job.i       = ci;
        job.j       = cj;
        job.element = ck;
        job.last    = (ci == dm1) && (cj == dm1);
      end
      MODE_LAP: begin
        job.kind = KIND_LAP;
      end
      default: begin
        job.kind = KIND_NONE;
      end
    endcase
  end

  // Advance the row and column counters while a multi-result item is issued
  always_comb begin
    busy_nxt = busy_r;
    hold_nxt = hold_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    elem_nxt = elem_r;
    if (job_valid) begin
      if (job.last) begin
        busy_nxt = 1'b0;
      end else begin
        busy_nxt = 1'b1;
        hold_nxt = src;
        elem_nxt = ck + 4'd1;
        if (src.mode == MODE_GRAD) begin
          row_nxt = ci + 2'd1;
          col_nxt = 2'd0;
        end else if (cj == dm1) begin
          row_nxt = ci + 2'd1;
          col_nxt = 2'd0;
        end else begin
          row_nxt = ci;
          col_nxt = cj + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      dim_r  <= 2'(DIM_RESET);
    end else begin
      busy_r <= busy_nxt;
      if (cfg_valid) dim_r <= cfg_dimension;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
    row_r  <= row_nxt;
    col_r  <= col_nxt;
    elem_r <= elem_nxt;
  end

  // Coordinate lanes
  assign pts[0] = src.point_x;
  assign pts[1] = src.point_y;
  assign pts[2] = src.point_z;
  assign cts[0] = src.centre_x;
  assign cts[1] = src.centre_y;
  assign cts[2] = src.centre_z;

  for (genvar l = 0; l < MAX_DIM; l++) begin : g_lane
    edd_lane u_lane (
      .clk     (clk),
      .lane_en (2'(l) < dim_eff),
      .point   (pts[l]),
      .centre  (cts[l]),
      .diff    (dl[l]),
      .sq      (sql[l])
    );
  end

  // Merge the lane squares into the squared distance
  always_comb begin
    s_sum = '0;
    for (int l = 0; l < MAX_DIM; l++) s_sum = s_sum + sql[l];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= job_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    j1_r    <= job;
    j2_r    <= j1_r;
    j3_r    <= j2_r;
    s3_r    <= s_sum;
    prod3_r <= dl[j2_r.i] * dl[j2_r.j];
    di3_r   <= dl[j2_r.i];
  end

  // Pick the dividend magnitude and sign for this job
  always_comb begin
    diag     = (j3_r.i == j3_r.j);
    prod_mag = prod3_r[SW-1] ? SW'(-prod3_r) : SW'(prod3_r);
    nmag     = diag ? (s3_r - SW'(prod3_r)) : prod_mag;
    nneg     = !diag && !prod3_r[SW-1] && (prod3_r != '0);
    di_mag   = di3_r[DW-1] ? DW'(-di3_r) : DW'(di3_r);
    pre4_nxt = '0;
    pre4_nxt.s           = s3_r;
    pre4_nxt.tag.kind    = j3_r.kind;
    pre4_nxt.tag.element = j3_r.element;
    pre4_nxt.tag.last    = j3_r.last;
    pre4_nxt.tag.status  = j3_r.status;
    case (j3_r.kind)
      KIND_D1: begin
        pre4_nxt.amag    = AW'(di_mag);
        pre4_nxt.tag.neg = di3_r[DW-1];
      end
      KIND_HESS: begin
        pre4_nxt.amag    = AW'(nmag);
        pre4_nxt.tag.neg = nneg;
      end
      KIND_LAP: begin
        pre4_nxt.amag    = AW'(j3_r.dm1);
      end
      default: begin
        pre4_nxt.amag    = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    pre4_r <= pre4_nxt;
  end

  edd_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v4_r),
    .in_pre    (pre4_r),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_pre   (sq_pre)
  );

  // Choose the first divisor from the root or the squared distance, or 1 for a zero root
  always_comb begin
    t1      = sq_pre.tag;
    t1.q    = sq_root;
    t1.zero = (sq_root == '0);
    case (sq_pre.tag.kind)
      KIND_D1:   b1 = BW'({sq_root, 16'b0});
      KIND_HESS: b1 = BW'(sq_pre.s);
      KIND_LAP:  b1 = BW'(sq_root);
      default:   b1 = BW'(1);
    endcase
    if (sq_root == '0) b1 = BW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vd1_r <= 1'b0;
    else vd1_r <= sq_v;
  end

  always_ff @(posedge clk) begin
    d1a_r <= sq_pre.amag;
    d1b_r <= b1;
    d1t_r <= t1;
  end

  edd_div u_div1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vd1_r),
    .in_a      (d1a_r),
    .in_b      (d1b_r),
    .in_tag    (d1t_r),
    .out_valid (dv1),
    .out_quo   (quo1),
    .out_tag   (dt1)
  );

  // Divide the Hessian term by the root again; pass other kinds through
  always_ff @(posedge clk) begin
    if (!rst_n) vd2_r <= 1'b0;
    else vd2_r <= dv1;
  end

  always_ff @(posedge clk) begin
    d2a_r <= AW'(quo1);
    d2b_r <= (dt1.kind == KIND_HESS && !dt1.zero) ? BW'({dt1.q, 32'b0}) : (BW'(1) << 32);
    d2t_r <= dt1;
  end

  edd_div u_div2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vd2_r),
    .in_a      (d2a_r),
    .in_b      (d2b_r),
    .in_tag    (d2t_r),
    .out_valid (dv2),
    .out_quo   (quo2),
    .out_tag   (dt2)
  );

  // Saturate and apply the zero-vector special values
  always_comb begin
    out_nxt         = '0;
    out_nxt.element = dt2.element;
    out_nxt.last    = dt2.last;
    out_nxt.status  = dt2.status;
    case (dt2.kind)
      KIND_DIST: out_nxt.value = $signed({7'b0, dt2.q});
      KIND_D1:   out_nxt.value = dt2.zero ? 32'sd65536 : edd_sat(quo2, dt2.neg);
      KIND_HESS: out_nxt.value = dt2.zero ? 32'sd0 : edd_sat(quo2, dt2.neg);
      KIND_LAP:  out_nxt.value = dt2.zero ? 32'sd0 : edd_sat(quo2, 1'b0);
      default:   out_nxt.value = 32'sd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_v_r <= 1'b0;
    else out_v_r <= dv2;
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_strobe = out_v_r;
  assign out_item   = out_r;

  // Busy only rises after an accepted beat
  a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a start");

  // Sequencer drops busy once the final job of an item is issued
  a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
    busy && job.last |=> !busy)
    else $error("busy held past the last job");

  // Results of one item leave back to back
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_item.last |=> out_strobe)
    else $error("gap inside a result burst");

  // An axis error is a single zero result
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.status |-> out_item.last && (out_item.value == 32'sd0))
    else $error("malformed error result");

endmodule

`default_nettype wire

### tb/sv/edd_checker.sv
// Checker for the distance derivative core: watches the channels, predicts results, compares.
`timescale 1ns / 100ps

module edd_checker import edd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     busy,
  input  edd_in_t  in_item,
  input  logic     out_strobe,
  input  edd_out_t out_item,
  input  logic     cfg_valid,
  input  logic     cfg_ready,
  input  logic [1:0] cfg_dimension,
  output int       fail_count,
  output int       pending,
  output int       items_seen,
  output int       results_seen
);

  localparam longint unsigned QUOT_CAP = 64'd1 << 40;

  edd_out_t    result_fifo[$];
  logic [1:0]  dim_reg;
  int          mode_hits[8];

  // Integer square root, bit by bit
  function automatic longint unsigned root_floor(input longint unsigned x);
    longint unsigned rest, acc, bitv;
    rest = x;
    acc  = 0;
    bitv = 64'd1 << 62;
    while (bitv > rest) bitv >>= 2;
    while (bitv != 0) begin
      if (rest >= acc + bitv) begin
        rest -= acc + bitv;
        acc = (acc >> 1) + bitv;
      end else begin
        acc >>= 1;
      end
      bitv >>= 2;
    end
    return acc;
  endfunction

  // floor(a * 2^k / b), capped
  function automatic longint unsigned scaled_quot(input longint unsigned a,
                                                  input longint unsigned b, input int k);
    longint unsigned qt, rm;
    qt = a / b;
    rm = a % b;
    if (qt >= QUOT_CAP) return QUOT_CAP;
    for (int n = 0; n < k; n++) begin
      rm <<= 1;
      qt <<= 1;
      if (rm >= b) begin
        rm -= b;
        qt |= 64'd1;
      end
      if (qt >= QUOT_CAP) return QUOT_CAP;
    end
    return qt;
  endfunction

  function automatic logic signed [31:0] clamp32(input longint unsigned mag, input logic neg);
    if (neg) return (mag >= 64'h80000000) ? 32'sh80000000 : 32'(-longint'(mag));
    return (mag >= 64'h7FFFFFFF) ? 32'sh7FFFFFFF : 32'(mag);
  endfunction

  function automatic longint unsigned abs64(input longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic logic signed [31:0] slope_of(input longint da, input longint unsigned q);
    if (q == 0) return 32'sd65536;
    return clamp32(scaled_quot(abs64(da), q, 16), da < 0);
  endfunction

  function automatic logic signed [31:0] curvature_of(input longint dv[3], input int i,
                                                      input int j, input longint unsigned s,
                                                      input longint unsigned q);
    longint n;
    if (s == 0) return 32'sd0;
    n = (i == j) ? longint'(s) - dv[i] * dv[i] : -(dv[i] * dv[j]);
    return clamp32(scaled_quot(scaled_quot(abs64(n), s, 32), q, 0), n < 0);
  endfunction

  task automatic push_result(input logic signed [31:0] v, input int el, input bit lst,
                             input bit st);
    edd_out_t r;
    r.value   = v;
    r.element = 4'(el);
    r.last    = lst;
    r.status  = st;
    result_fifo.push_back(r);
  endtask

  // Expand one accepted item into its expected results
  task automatic predict_item(input edd_in_t it);
    longint          dv[3];
    longint unsigned s, q;
    int              dim, k;
    dv  = '{0, 0, 0};
    dim = (dim_reg == 0) ? 1 : int'(dim_reg);
    s   = 0;
    dv[0] = longint'($signed(it.point_x)) - longint'($signed(it.centre_x));
    dv[1] = longint'($signed(it.point_y)) - longint'($signed(it.centre_y));
    dv[2] = longint'($signed(it.point_z)) - longint'($signed(it.centre_z));
    for (int i = 0; i < 3; i++) begin
      if (i >= dim) dv[i] = 0;
      s += longint'(dv[i] * dv[i]);
    end
    q = root_floor(s);
    case (it.mode)
      MODE_DIST: push_result(clamp32(q, 1'b0), 0, 1, 0);
      MODE_D1, MODE_D2: begin
        if (int'(it.axis) >= dim) push_result(0, 0, 1, 1);
        else if (it.mode == MODE_D1) push_result(slope_of(dv[it.axis], q), 0, 1, 0);
        else push_result(curvature_of(dv, it.axis, it.axis, s, q), 0, 1, 0);
      end
      MODE_GRAD: begin
        for (int i = 0; i < dim; i++) push_result(slope_of(dv[i], q), i, i == dim - 1, 0);
      end
      MODE_HESS: begin
        k = 0;
        for (int i = 0; i < dim; i++)
          for (int j = 0; j < dim; j++) begin
            push_result(curvature_of(dv, i, j, s, q), k, k == dim * dim - 1, 0);
            k++;
          end
      end
      MODE_LAP: begin
        if (q == 0) push_result(0, 0, 1, 0);
        else push_result(clamp32(scaled_quot(longint'(dim - 1), q, 32), 1'b0), 0, 1, 0);
      end
      default: push_result(0, 0, 1, 0);
    endcase
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  assign pending = result_fifo.size();

  // Track config, predict on input beats, compare on result beats
  always @(posedge clk) begin
    edd_out_t exp_r;
    if (!rst_n) begin
      dim_reg <= 2'(DIM_RESET);
    end else begin
      if (cfg_valid && cfg_ready) dim_reg <= cfg_dimension;
      if (start && !busy) begin
        predict_item(in_item);
        items_seen++;
        mode_hits[in_item.mode]++;
      end
      if (out_strobe) begin
        results_seen++;
        if (result_fifo.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", out_item));
        end else begin
          exp_r = result_fifo.pop_front();
          if (out_item.value !== exp_r.value)
            report_mismatch($sformatf("value %h, want %h", out_item.value, exp_r.value));
          if (out_item.element !== exp_r.element)
            report_mismatch($sformatf("element %0d, want %0d", out_item.element,
                                      exp_r.element));
          if (out_item.last !== exp_r.last)
            report_mismatch($sformatf("last %b, want %b", out_item.last, exp_r.last));
          if (out_item.status !== exp_r.status)
            report_mismatch($sformatf("status %b, want %b", out_item.status, exp_r.status));
        end
      end
    end
  end

  initial begin
    fail_count   = 0;
    items_seen   = 0;
    results_seen = 0;
    foreach (mode_hits[m]) mode_hits[m] = 0;
  end

endmodule

### tb/sv/testbench.sv
// Testbench top: clock, reset, stimulus for the distance derivative core and the verdict.
`timescale 1ns / 100ps

module testbench;
  import edd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PIPE_DRAIN  = 130;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  edd_in_t    in_item;
  logic       out_strobe;
  edd_out_t   out_item;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_dimension;
  int         fail_count, pending, items_seen, results_seen;
  int         cycles;
  bit         no_gaps;
  logic [1:0] cur_dim;

  euclidean_distance_derivatives_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_dimension(cfg_dimension)
  );

  edd_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_dimension(cfg_dimension), .fail_count(fail_count),
    .pending(pending), .items_seen(items_seen), .results_seen(results_seen)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** euclidean_distance_derivatives_core: FAILED **");
      $finish;
    end
  end

  // Drive one beat and hold it until accepted; random gaps before it.
  // Start stays high after the accepting edge; the next beat or an idle drops it.
  task automatic send_beat(input edd_in_t it);
    while (!no_gaps && $urandom_range(99) < 6) begin
      start <= 1'b0;
      in_item <= edd_in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      @(negedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    @(negedge clk);
  endtask

  // Let the pipeline drain, then write the dimension
  task automatic set_dimension(input logic [1:0] d);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (PIPE_DRAIN) @(negedge clk);
    cfg_valid     <= 1'b1;
    cfg_dimension <= d;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    cfg_dimension <= 2'($urandom);
    cur_dim = d;
  endtask

  function automatic logic signed [23:0] rand_coord();
    case ($urandom_range(5))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2: return 24'($signed($urandom_range(0, 8192)) - 4096);
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic edd_in_t rand_item();
    edd_in_t it;
    it.mode     = ($urandom_range(99) < 8) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
    it.axis     = 2'($urandom);
    it.point_x  = rand_coord();
    it.point_y  = rand_coord();
    it.point_z  = rand_coord();
    it.centre_x = rand_coord();
    it.centre_y = rand_coord();
    it.centre_z = rand_coord();
    // Keep some pairs close or equal
    if ($urandom_range(9) == 0) begin
      it.centre_x = it.point_x;
      it.centre_y = it.point_y;
      it.centre_z = it.point_z;
    end else if ($urandom_range(5) == 0) begin
      it.centre_x = it.point_x + 24'($urandom_range(3));
      it.centre_y = it.point_y - 24'($urandom_range(3));
    end
    return it;
  endfunction

  function automatic edd_in_t make_item(input logic [2:0] m, input logic [1:0] ax,
                                        input logic signed [23:0] p, input logic signed [23:0] c);
    edd_in_t it;
    it.mode = m; it.axis = ax;
    it.point_x = p; it.point_y = -p; it.point_z = p;
    it.centre_x = c; it.centre_y = c; it.centre_z = -c;
    return it;
  endfunction

  initial begin
    logic [1:0] dims[5];
    cycles        = 0;
    no_gaps       = 1'b0;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_item       = '0;
    cfg_valid     = 1'b0;
    cfg_dimension = 2'd0;
    cur_dim       = 2'(DIM_RESET);
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: every mode, extremes, zero difference, axis out of range
    for (int m = 0; m < 8; m++)
      send_beat(make_item(3'(m), 2'd1, 24'sh7FFFFF, 24'sh800000));
    send_beat(make_item(MODE_D1, 2'd0, 24'sh000100, 24'sh000100));
    send_beat(make_item(MODE_GRAD, 2'd0, 24'sh123456, 24'sh123456));
    send_beat(make_item(MODE_HESS, 2'd0, 24'sh0, 24'sh0));
    send_beat(make_item(MODE_LAP, 2'd0, 24'sh0, 24'sh0));
    send_beat(make_item(MODE_D2, 2'd0, 24'sh000001, 24'sh0));
    send_beat(make_item(MODE_D1, 2'd3, 24'sh010000, 24'sh0));
    send_beat(make_item(MODE_D2, 2'd3, 24'sh010000, 24'sh0));
    send_beat(make_item(MODE_LAP, 2'd2, 24'sh000001, 24'sh0));
    set_dimension(2'd1);
    send_beat(make_item(MODE_D1, 2'd1, 24'sh010000, 24'sh0));
    send_beat(make_item(MODE_D2, 2'd2, 24'sh010000, 24'sh0));
    send_beat(make_item(MODE_HESS, 2'd0, 24'sh7FFFFF, 24'sh800000));
    send_beat(make_item(MODE_LAP, 2'd0, 24'sh7FFFFF, 24'sh800000));
    send_beat(make_item(MODE_D2, 2'd0, 24'sh7FFFFF, 24'sh800000));

    // Random phases over several dimensions; the middle phase runs without gaps
    dims = '{2'd3, 2'd2, 2'd0, 2'd1, 2'd3};
    for (int ph = 0; ph < 5; ph++) begin
      set_dimension(dims[ph]);
      no_gaps = (ph == 2);
      for (int n = 0; n < 66; n++) send_beat(rand_item());
    end
    no_gaps = 1'b0;
    start <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (PIPE_DRAIN) @(negedge clk);
    $display("covered %0d items over dimensions 1..3 and all modes, %0d results checked",
             items_seen, results_seen);
    if (fail_count == 0) begin
      $display("** euclidean_distance_derivatives_core: PASSED **");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("** euclidean_distance_derivatives_core: FAILED **");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/edd_pkg.sv
hw/rtl/edd_lane.sv
hw/rtl/edd_sqrt.sv
hw/rtl/edd_div.sv
hw/rtl/euclidean_distance_derivatives_core.sv
tb/sv/edd_checker.sv
tb/sv/testbench.sv
